[rtl/mma_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mma_pkg
// Shared constants for the Q8.8 matrix multiply-accumulate block: sizes,
// index widths, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package mma_pkg;

	// array dimensions
	localparam int MAX_ROWS  = 16;
	localparam int MAX_COLS  = 16;
	localparam int MAX_INNER = 16;

	localparam int IDX_W   = 4;          // row / column / inner index bits
	localparam int SIZE_W  = 5;          // size register bits
	localparam int DATA_W  = 16;         // Q8.8 element
	localparam int ADDR_W  = 2 * IDX_W;  // store address bits
	localparam int DEPTH   = 1 << ADDR_W;

	// arithmetic widths
	localparam int PROD_W  = 2 * DATA_W;     // Q16.16 product
	localparam int ACC_W   = PROD_W + 4;     // sum of up to 16 products
	localparam int SCL_W   = ACC_W + DATA_W; // acc times alpha, Q28.24
	localparam int TOT_W   = SCL_W + 1;      // plus aligned beta term
	localparam int Q_W     = TOT_W - 16;     // after dropping 16 fraction bits

	// APB
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_LOAD_A  = 2'd0;
	localparam cmd_t CMD_LOAD_B  = 2'd1;
	localparam cmd_t CMD_LOAD_C  = 2'd2;
	localparam cmd_t CMD_COMPUTE = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_ALPHA = 3'd0;
	localparam reg_idx_t REG_BETA  = 3'd1;
	localparam reg_idx_t REG_ROWS  = 3'd2;
	localparam reg_idx_t REG_COLS  = 3'd3;
	localparam reg_idx_t REG_INNER = 3'd4;

	localparam logic [DATA_W-1:0] ALPHA_RST = 16'd256;
	localparam logic [DATA_W-1:0] BETA_RST  = 16'd0;
	localparam logic [SIZE_W-1:0] ROWS_RST  = 5'd16;
	localparam logic [SIZE_W-1:0] COLS_RST  = 5'd16;
	localparam logic [SIZE_W-1:0] INNER_RST = 5'd16;

	localparam logic [SIZE_W-1:0] ROWS_MAX  = SIZE_W'(MAX_ROWS);
	localparam logic [SIZE_W-1:0] COLS_MAX  = SIZE_W'(MAX_COLS);
	localparam logic [SIZE_W-1:0] INNER_MAX = SIZE_W'(MAX_INNER);

endpackage : mma_pkg
`default_nettype wire

[rtl/matrix_multiply_accumulate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Load words write one element of A, B or C; a compute word returns
// alpha*dot(A row, B col) + beta*C in Q8.8 and writes it back to C.
// Timing: loads take effect at acceptance, busy stays low. A compute word
//   keeps busy high through one A/B read per inner term, the drain of the
//   read, multiply and accumulate registers, the scale multiply state and
//   the sum state. The result strobe comes in the next cycle.
// Throughput: no word is accepted while a compute word keeps busy high;
//   loads are accepted every cycle while busy is low.
// Reset: config registers take reset values and all of C reads as zero
//   (valid bits); A and B hold garbage until written. Results are not stalled.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate
	import mma_pkg::*;
(
	input  wire                       clk,
	input  wire                       arst_n,
	// command side
	input  wire                       start,
	output logic                      busy,
	input  wire  [1:0]                cmd,
	input  wire  [IDX_W-1:0]          row,
	input  wire  [IDX_W-1:0]          col,
	input  wire  signed [DATA_W-1:0]  value,
	// result side
	output logic                      done,
	output logic [IDX_W-1:0]          out_row,
	output logic [IDX_W-1:0]          out_col,
	output logic signed [DATA_W-1:0]  result,
	output logic                      saturated,
	// configuration
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire  [PADDR_W-1:0]        paddr,
	input  wire  [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_SCALE = 3'd3;
	localparam logic [2:0] S_SUM   = 3'd4;

	// configuration registers
	logic signed [DATA_W-1:0] alpha_q, beta_q;
	logic [SIZE_W-1:0]        rows_q, cols_q, inner_q;
	logic                     cfg_wr;
	reg_idx_t                 cfg_idx;

	// clamped sizes
	logic [SIZE_W-1:0] nr, nc, nk;

	// control
	logic [2:0]        state_q;
	logic [SIZE_W-1:0] k_q;
	logic [SIZE_W-1:0] nk_q;
	logic [IDX_W-1:0]  r_q, c_q;
	logic              accept, issue;
	logic              in_rc, do_compute;
	logic              v_s1, v_s2;

	// stores
	logic signed [DATA_W-1:0] a_mem [DEPTH];
	logic signed [DATA_W-1:0] b_mem [DEPTH];
	logic signed [DATA_W-1:0] c_mem [DEPTH];
	logic [DEPTH-1:0]         c_valid_q;
	logic [ADDR_W-1:0]        a_raddr, b_raddr, c_addr;
	logic                     a_we, b_we, c_we;
	logic [ADDR_W-1:0]        c_waddr;
	logic signed [DATA_W-1:0] c_wdata;

	// datapath
	logic signed [DATA_W-1:0] a_rd_s1, b_rd_s1;
	logic signed [DATA_W-1:0] c_rd_q;
	logic                     c_ok_q;
	logic signed [DATA_W-1:0] c_val;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [SCL_W-1:0]  m_alpha_q;
	logic signed [PROD_W-1:0] m_beta_q;
	logic signed [TOT_W-1:0]  total;
	logic [Q_W-1:0]           q;
	logic                     sat_hi, sat_lo;
	logic signed [DATA_W-1:0] q_clip;

	// APB
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q  <= BETA_RST;
			rows_q  <= ROWS_RST;
			cols_q  <= COLS_RST;
			inner_q <= INNER_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ALPHA: alpha_q <= pwdata[DATA_W-1:0];
				REG_BETA:  beta_q  <= pwdata[DATA_W-1:0];
				REG_ROWS:  rows_q  <= pwdata[SIZE_W-1:0];
				REG_COLS:  cols_q  <= pwdata[SIZE_W-1:0];
				REG_INNER: inner_q <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ALPHA: prdata = {{(PDATA_W-DATA_W){1'b0}}, alpha_q};
			REG_BETA:  prdata = {{(PDATA_W-DATA_W){1'b0}}, beta_q};
			REG_ROWS:  prdata = {{(PDATA_W-SIZE_W){1'b0}}, rows_q};
			REG_COLS:  prdata = {{(PDATA_W-SIZE_W){1'b0}}, cols_q};
			REG_INNER: prdata = {{(PDATA_W-SIZE_W){1'b0}}, inner_q};
			default:   prdata = '0;
		endcase
	end

	// sizes above the array limits clamp
	assign nr = (rows_q  > ROWS_MAX)  ? ROWS_MAX  : rows_q;
	assign nc = (cols_q  > COLS_MAX)  ? COLS_MAX  : cols_q;
	assign nk = (inner_q > INNER_MAX) ? INNER_MAX : inner_q;

	// command decode
	assign busy       = (state_q != S_IDLE);
	assign accept     = start && !busy;
	assign in_rc      = ({1'b0, row} < nr) && ({1'b0, col} < nc);
	assign do_compute = accept && (cmd == CMD_COMPUTE) && in_rc;
	assign a_we       = accept && (cmd == CMD_LOAD_A) && ({1'b0, row} < nr)
	                    && ({1'b0, col} < nk);
	assign b_we       = accept && (cmd == CMD_LOAD_B) && ({1'b0, row} < nk)
	                    && ({1'b0, col} < nc);
	assign c_we       = (accept && (cmd == CMD_LOAD_C) && in_rc) || (state_q == S_SUM);
	assign c_waddr    = (state_q == S_SUM) ? {r_q, c_q} : {row, col};
	assign c_wdata    = (state_q == S_SUM) ? q_clip : value;

	// one A/B read per inner term
	assign issue   = (state_q == S_READ) && (k_q != nk_q);
	assign a_raddr = {r_q, k_q[IDX_W-1:0]};
	assign b_raddr = {k_q[IDX_W-1:0], c_q};
	assign c_addr  = {r_q, c_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			case (state_q)
				S_IDLE: begin
					k_q <= '0;
					if (do_compute) state_q <= S_READ;
				end
				S_READ: begin
					if (issue) k_q <= k_q + SIZE_W'(1);
					if (!issue || (k_q + SIZE_W'(1) == nk_q)) state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) state_q <= S_SCALE;
				end
				S_SCALE: state_q <= S_SUM;
				S_SUM:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (do_compute) begin
			r_q  <= row;
			c_q  <= col;
			nk_q <= nk;
		end
	end

	// stores: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (a_we) a_mem[{row, col}] <= value;
		if (b_we) b_mem[{row, col}] <= value;
		if (c_we) c_mem[c_waddr] <= c_wdata;
		a_rd_s1 <= a_mem[a_raddr];
		b_rd_s1 <= b_mem[b_raddr];
		c_rd_q  <= c_mem[c_addr];
	end

	// C reads zero until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_valid_q <= '0;
			c_ok_q    <= 1'b0;
		end else begin
			if (c_we) c_valid_q[c_waddr] <= 1'b1;
			c_ok_q <= c_valid_q[c_addr];
		end
	end

	assign c_val = c_ok_q ? c_rd_q : '0;

	// multiply and accumulate the dot product
	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (do_compute) acc_q <= '0;
		else if (v_s2)  acc_q <= acc_q + ACC_W'(prod_s2);
	end

	// scale terms
	always_ff @(posedge clk) begin
		if (state_q == S_SCALE) begin
			m_alpha_q <= acc_q * alpha_q;
			m_beta_q  <= beta_q * c_val;
		end
	end

	// align, floor to Q8.8, saturate
	assign total  = TOT_W'(m_alpha_q) + (TOT_W'(m_beta_q) <<< 8);
	assign q      = total[TOT_W-1:16];
	assign sat_hi = !q[Q_W-1] && (q[Q_W-2:DATA_W-1] != '0);
	assign sat_lo = q[Q_W-1] && (q[Q_W-2:DATA_W-1] != '1);
	assign q_clip = sat_hi ? 16'sh7FFF : (sat_lo ? 16'sh8000 : q[DATA_W-1:0]);

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == S_SUM);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SUM) begin
			out_row   <= r_q;
			out_col   <= c_q;
			result    <= q_clip;
			saturated <= sat_hi || sat_lo;
		end
	end

	// checks
	a_done_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |=> done)
		else $error("result strobe missing after sum cycle");

	a_done_only_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_SUM))
		else $error("result strobe without a sum cycle");

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd != CMD_COMPUTE)) |=> !busy)
		else $error("load word left the block busy");

	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCALE) |-> (!v_s1 && !v_s2))
		else $error("scale started before products drained");

	a_pipe_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ((state_q == S_READ) || (state_q == S_DRAIN)))
		else $error("product in flight outside the read phase");

endmodule : matrix_multiply_accumulate
`default_nettype wire
